// ----- sv/lcg_rrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random range draw package
// Constants and types shared by the generator, the modular multiplier and the
// serial remainder unit.
// ----------------------------------------------------------------------------
package lcg_rrd_pkg;

    localparam int unsigned GEN_W   = 31;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MULT_W  = 16;
    localparam int unsigned MULT_CW = $clog2(MULT_W);
    localparam int unsigned DIV_CW  = $clog2(GEN_W);

    localparam logic [MULT_W-1:0] LCG_MULT    = 16'd40692;
    localparam logic [GEN_W-1:0]  LCG_MODULUS = 31'd2147483399;
    localparam logic [DATA_W-1:0] LCG_MOD_X2  = 32'd4294966798;
    localparam logic [GEN_W-1:0]  SEED_RESET  = 31'd1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } draw_state_t;

endpackage

// ----- sv/lcg_rrd_mulmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Forms operand times the generator multiplier modulo the generator modulus,
// one multiplier bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module lcg_rrd_mulmod
    import lcg_rrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [GEN_W-1:0] operand,
    output logic             done,
    output logic [GEN_W-1:0] result
);

    logic [GEN_W-1:0]   acc_reg;
    logic [GEN_W-1:0]   acc_next;
    logic [GEN_W-1:0]   mcand_reg;
    logic [GEN_W-1:0]   mcand_init;
    logic [MULT_CW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [GEN_W+1:0]   sum;
    logic [GEN_W+1:0]   red1;
    logic [GEN_W+1:0]   red2;

    // The seed may lie at or above the modulus, so it is brought into range once.
    assign mcand_init = (operand >= LCG_MODULUS) ? (operand - LCG_MODULUS) : operand;

    // Both terms are below the modulus, so the sum is below three times the modulus.
    assign sum  = {1'b0, acc_reg, 1'b0}
                + (LCG_MULT[cnt_reg] ? {2'b00, mcand_reg} : {(GEN_W+2){1'b0}});
    assign red1 = sum - {2'b00, LCG_MODULUS};
    assign red2 = sum - {1'b0, LCG_MOD_X2};

    always_comb
    begin
        if (sum >= {1'b0, LCG_MOD_X2})
        begin
            acc_next = red2[GEN_W-1:0];
        end
        else if (sum >= {2'b00, LCG_MODULUS})
        begin
            acc_next = red1[GEN_W-1:0];
        end
        else
        begin
            acc_next = sum[GEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MULT_CW'(MULT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mcand_reg <= mcand_init;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- sv/lcg_rrd_divrem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division that shifts in one dividend bit per cycle and keeps only
// the remainder.
// ----------------------------------------------------------------------------
module lcg_rrd_divrem
    import lcg_rrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [GEN_W-1:0] dividend,
    input  logic [GEN_W-1:0] divisor,
    output logic             done,
    output logic [GEN_W-1:0] remainder
);

    logic [GEN_W-1:0]  rem_reg;
    logic [GEN_W-1:0]  dvd_reg;
    logic [GEN_W-1:0]  dsr_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [GEN_W:0]    trial;
    logic [GEN_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[GEN_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(GEN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[GEN_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= diff[GEN_W-1:0];
            end
            else
            begin
                rem_reg <= trial[GEN_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/lcg_random_range_draw_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random range draw unit
// Draws a value in a half-open signed range from a multiplicative congruential
// generator, using a bit-serial modular multiplier and a bit-serial remainder.
// ----------------------------------------------------------------------------
// Each transaction on the input stream carries a low bound and an exclusive
// high bound and produces exactly one transaction on the output stream.
// A range of positive width advances the generator by 16 multiplier steps and
// reduces the new value by the width in 31 remainder steps; the result then
// moves into the output register, and only then is the next input taken.
// An empty or reversed range leaves the generator alone and skips both serial
// loops, so its result moves straight on to the output register.
// One item is processed at a time; the input is ready only while idle.
// The result sits in an output register, so a new input is taken while the
// previous result still waits. If the receiver stalls, the finished result of
// the next item is held inside until the output register is free.
// The configuration channel is always ready; a write loads the generator with
// the seed and should only be issued while no draw is in flight.
// Reset loads the generator with 1 and empties the output register.
// ----------------------------------------------------------------------------
module lcg_random_range_draw_unit
    import lcg_rrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GEN_W-1:0]  cfg_data,       // seed
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // low_bound [31:0], high_bound [63:32]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // value [31:0]
    output logic [0:0]        m_axis_tuser    // stepped [0]
);

    draw_state_t       state_reg;
    draw_state_t       state_next;
    logic [GEN_W-1:0]  gen_reg;
    logic [DATA_W-1:0] low_reg;
    logic [GEN_W-1:0]  width_reg;
    logic [DATA_W-1:0] res_value_reg;
    logic              res_stepped_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_stepped_reg;

    logic [DATA_W-1:0] in_low;
    logic [DATA_W-1:0] in_high;
    logic [DATA_W-1:0] width;
    logic              in_fire;
    logic              out_load;
    logic              mul_start;
    logic              mul_done;
    logic [GEN_W-1:0]  mul_result;
    logic              div_start;
    logic              div_done;
    logic [GEN_W-1:0]  div_rem;

    assign in_low   = s_axis_tdata[31:0];
    assign in_high  = s_axis_tdata[63:32];
    assign width    = in_high - in_low;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign mul_start = in_fire && !width[DATA_W-1] && (width != '0);
    assign div_start = (state_reg == ST_MUL) && mul_done;

    lcg_rrd_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (gen_reg),
        .done    (mul_done),
        .result  (mul_result)
    );

    lcg_rrd_divrem u_divrem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mul_result),
        .divisor   (width_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = mul_start ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                gen_reg <= cfg_data;
            end
            else if (div_start)
            begin
                gen_reg <= mul_result;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            low_reg         <= in_low;
            width_reg       <= width[GEN_W-1:0];
            res_stepped_reg <= 1'b0;
            if (width[DATA_W-1])
            begin
                res_value_reg <= '0;
            end
            else
            begin
                res_value_reg <= in_low;
            end
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            res_value_reg   <= low_reg + {1'b0, div_rem};
            res_stepped_reg <= 1'b1;
        end
        if (out_load)
        begin
            out_value_reg   <= res_value_reg;
            out_stepped_reg <= res_stepped_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_stepped_reg;

endmodule

// ----- sv/lcg_rrd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random range draw port checker
// Watches the ports of the draw unit and flags sequencing faults.
// ----------------------------------------------------------------------------
module lcg_rrd_checker
    import lcg_rrd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [GEN_W-1:0]  cfg_data,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [63:0]       s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [0:0]        m_axis_tuser
);

    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled output transaction changed.");

    // Once an item is taken, no other is taken until it has been finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("Input accepted while an item is in flight.");

    // A fresh result is posted only as the unit returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("Result posted while the unit is still busy.");

    // No result can follow its input transaction in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("Result appeared too early after an input transaction.");

    // Configuration is never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("Configuration transaction stalled.");

endmodule

bind lcg_random_range_draw_unit lcg_rrd_checker u_lcg_rrd_checker (.*);

// ----- dv/lcg_draw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random range draw checker
// Watches the seed, request and result channels of the draw unit. It keeps a
// private copy of the generator, works out the draw for every request
// transaction, and compares each result transaction field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lcg_draw_checker
    import lcg_rrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [GEN_W-1:0]  cfg_data,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,
    input  logic [0:0]        m_axis_tuser,
    output int                pending_draws,
    output int                fail_count,
    output int                stepped_draws,
    output int                held_draws
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              stepped;
    } draw_result_t;

    draw_result_t     expected_draws[$];
    logic [GEN_W-1:0] gen_state;
    int               mismatches;
    int               stepped_total;
    int               held_total;

    function draw_result_t predict_draw(input logic [DATA_W-1:0] lo,
                                        input logic [DATA_W-1:0] hi);
        logic [DATA_W-1:0] span;
        logic [63:0]       gen_wide;
        logic [63:0]       product;
        logic [63:0]       reduced;
        draw_result_t      draw;
        span         = hi - lo;
        draw.value   = '0;
        draw.stepped = 1'b0;
        if (span == '0)
        begin
            draw.value = lo;
        end
        else if (!span[DATA_W-1])
        begin
            gen_wide     = gen_state;
            product      = gen_wide * LCG_MULT;
            reduced      = product % LCG_MODULUS;
            gen_state    = reduced[GEN_W-1:0];
            draw.value   = lo + (gen_state % span);
            draw.stepped = 1'b1;
        end
        return draw;
    endfunction

    task report_mismatch(input string what, input draw_result_t want,
                         input draw_result_t got);
        if (mismatches < REPORT_LIMIT)
        begin
            $display("%0t: %s: value expected %0d got %0d, stepped expected %0d got %0d",
                     $realtime, what, $signed(want.value), $signed(got.value),
                     want.stepped, got.stepped);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        draw_result_t got;
        if (!rst_n)
        begin
            expected_draws.delete();
            gen_state     = SEED_RESET;
            mismatches    = 0;
            stepped_total = 0;
            held_total    = 0;
            pending_draws <= 0;
            fail_count    <= 0;
            stepped_draws <= 0;
            held_draws    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gen_state = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value   = m_axis_tdata;
                got.stepped = m_axis_tuser[0];
                if (expected_draws.size() == 0)
                begin
                    want = '0;
                    report_mismatch("Result transaction with no request pending", want, got);
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (want.value !== got.value || want.stepped !== got.stepped)
                    begin
                        report_mismatch("Draw mismatch", want, got);
                    end
                    if (want.stepped)
                    begin
                        stepped_total++;
                    end
                    else
                    begin
                        held_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_draws.push_back(predict_draw(s_axis_tdata[31:0],
                                                      s_axis_tdata[63:32]));
            end
            pending_draws <= expected_draws.size();
            fail_count    <= mismatches;
            stepped_draws <= stepped_total;
            held_draws    <= held_total;
        end
    end

endmodule

// ----- dv/lcg_random_range_draw_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Random range draw unit testbench
// Drives directed and random range requests into the draw unit under several
// seeds and handshake pacing mixes, and leaves prediction and comparison to
// the checker that sits beside the unit.
// ----------------------------------------------------------------------------
module lcg_random_range_draw_unit_test;
    import lcg_rrd_pkg::*;

    localparam int          CLK_HALF         = 4;
    localparam int          RESET_CYCLES     = 10;
    localparam int          CYCLE_LIMIT      = 400000;
    localparam int          RANDOM_PER_PHASE = 200;
    localparam int          DRAIN_EVERY      = 70;
    localparam int          DRAIN_EXTRA      = 60;
    localparam logic [31:0] RAW_HIGH         = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN          = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic [GEN_W-1:0]  cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [63:0]       s_axis_tdata  = '0;
    logic              m_axis_tready = 1'b0;
    logic              cfg_ready;
    logic              s_axis_tready;
    logic              m_axis_tvalid;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int draws_sent    = 0;
    int seeds_loaded  = 0;
    int pending_draws;
    int fail_count;
    int stepped_draws;
    int held_draws;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    lcg_random_range_draw_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lcg_draw_checker draw_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending_draws (pending_draws),
        .fail_count    (fail_count),
        .stepped_draws (stepped_draws),
        .held_draws    (held_draws)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d draws outstanding.",
                     pending_draws);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task send_draw(input logic [31:0] lo, input logic [31:0] hi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
        draws_sent++;
    endtask

    task wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_draws != 0)
        begin
            @(posedge clk);
        end
    endtask

    task load_seed(input logic [GEN_W-1:0] seed);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seeds_loaded++;
    endtask

    // Mostly bounded and raw draws and narrow ranges, with some empty,
    // reversed and fully random endpoint pairs mixed in.
    task random_draw;
        logic [31:0] lo;
        logic [31:0] hi;
        int          pick;
        pick = $urandom_range(99);
        lo   = $urandom;
        hi   = $urandom;
        if (pick < 35)
        begin
            lo = '0;
            hi = $urandom_range(1) ? $urandom_range(1, 1000) : {1'b0, hi[30:0]};
        end
        else if (pick < 50)
        begin
            lo = '0;
            hi = RAW_HIGH;
        end
        else if (pick < 75)
        begin
            hi = lo + $urandom_range(1, 256);
        end
        else if (pick < 80)
        begin
            hi = lo;
        end
        else if (pick < 90)
        begin
            hi = lo - $urandom_range(1, 1000);
        end
        send_draw(lo, hi);
    endtask

    task run_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            random_draw();
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        logic [31:0] seed_word;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_draw(32'd0, RAW_HIGH);
        send_draw(32'd0, 32'd1);
        send_draw(INT_MIN, RAW_HIGH);
        send_draw(RAW_HIGH, INT_MIN);
        send_draw(32'd5, 32'd5);
        send_draw(INT_MIN, INT_MIN);
        send_draw(32'd10, 32'd3);
        send_draw(-32'sd100, 32'sd100);
        send_draw(INT_MIN, 32'd0);
        send_draw(32'hC000_0000, 32'h3FFF_FFFF);
        send_draw(ALL_ONES, 32'h7FFF_FFFE);
        send_draw(32'd1, INT_MIN);
        send_draw(ALL_ONES, 32'd0);
        send_draw(32'hAAAA_AAAA, 32'h5555_5555);
        send_draw(32'h5555_5555, 32'hAAAA_AAAA);

        // A zero seed pins the generator at zero.
        load_seed('0);
        send_draw(32'd0, 32'd100);
        send_draw(-32'sd7, 32'sd9);
        send_draw(32'd0, RAW_HIGH);

        load_seed(LCG_MODULUS - 1'b1);
        send_draw(32'd0, RAW_HIGH);
        send_draw(-32'sd50, 32'sd50);

        // Seeds at and above the modulus are reduced by the first step.
        load_seed(LCG_MODULUS);
        send_draw(32'd0, RAW_HIGH);
        load_seed({GEN_W{1'b1}});
        send_draw(32'd0, RAW_HIGH);
        send_draw(32'd0, 32'd3);

        load_seed(SEED_RESET);
        run_random(RANDOM_PER_PHASE, 14, 65);
        load_seed(GEN_W'($urandom_range(1, LCG_MODULUS - 1)));
        run_random(RANDOM_PER_PHASE, 65, 14);
        seed_word = $urandom;
        load_seed(seed_word[GEN_W-1:0]);
        run_random(RANDOM_PER_PHASE, 0, 0);

        wait_drained();
        repeat (DRAIN_EXTRA) @(posedge clk);

        $display("Sent %0d range requests under %0d seed loads and three pacing mixes.",
                 draws_sent, seeds_loaded);
        $display("Results checked: %0d generator steps, %0d empty or reversed ranges.",
                 stepped_draws, held_draws);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
